/* sv/tmtw_pkg.sv */
package tmtw_pkg;

	// Screen geometry.
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	// Field and register widths.
	localparam int POS_W  = 11;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int CELL_W = 16;
	localparam int STEP_W = 5;

	// Character and attribute constants.
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] RESET_COLOR  = 8'h0F;

	// Opcodes of an input word.
	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_SET   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// Branch conditions of a microcode step.
	typedef enum logic [3:0] {
		C_NEXT,
		C_JUMP,
		C_NO_IN,
		C_OP_PUT,
		C_OP_READ,
		C_OP_SET,
		C_NL,
		C_BS,
		C_COL0,
		C_COL_LAST,
		C_ROW_LAST,
		C_FILL_MORE,
		C_COPY_MORE,
		C_ITEM,
		C_OUT_BUSY,
		C_CELL_OOR
	} cond_t;

	// Sweep address operations.
	typedef enum logic [1:0] {
		A_HOLD,
		A_ZERO,
		A_INC
	} addr_op_t;

	// Read port selection.
	typedef enum logic [1:0] {
		R_NONE,
		R_CELL,
		R_AHEAD
	} rd_sel_t;

	// Write port selection.
	typedef enum logic [2:0] {
		W_NONE,
		W_BLANK_ADDR,
		W_BLANK_POS,
		W_CHAR_POS,
		W_COPY_ADDR
	} wr_sel_t;

	// Cursor operations.
	typedef enum logic [2:0] {
		K_HOLD,
		K_HOME,
		K_ADV,
		K_BACK,
		K_NEWL,
		K_BOTTOM
	} cur_op_t;

	// One control word of the microprogram.
	typedef struct packed {
		cond_t             cond;
		logic [STEP_W-1:0] target;
		addr_op_t          addr_op;
		rd_sel_t           rd;
		wr_sel_t           wr;
		cur_op_t           cur;
		logic              ld_color;
		logic              ld_value;
		logic              emit;
		logic              wait_in;
	} ctrl_t;

	// Datapath status seen by the sequencer.
	typedef struct packed {
		logic in_take;
		logic op_put;
		logic op_read;
		logic op_set;
		logic is_nl;
		logic is_bs;
		logic col0;
		logic col_last;
		logic row_last;
		logic fill_more;
		logic copy_more;
		logic item;
		logic out_busy;
		logic cell_oor;
	} flags_t;

	// Microprogram step addresses.
	localparam logic [STEP_W-1:0] S_IDLE      = 5'd0;
	localparam logic [STEP_W-1:0] S_DISP      = 5'd1;
	localparam logic [STEP_W-1:0] S_DISP_RD   = 5'd2;
	localparam logic [STEP_W-1:0] S_COLOR     = 5'd3;
	localparam logic [STEP_W-1:0] S_CLEAR     = 5'd4;
	localparam logic [STEP_W-1:0] S_FILL      = 5'd5;
	localparam logic [STEP_W-1:0] S_HOME      = 5'd6;
	localparam logic [STEP_W-1:0] S_TO_IDLE   = 5'd7;
	localparam logic [STEP_W-1:0] S_READ      = 5'd8;
	localparam logic [STEP_W-1:0] S_READ_DATA = 5'd9;
	localparam logic [STEP_W-1:0] S_PUT       = 5'd10;
	localparam logic [STEP_W-1:0] S_PUT_BS    = 5'd11;
	localparam logic [STEP_W-1:0] S_PUT_CHAR  = 5'd12;
	localparam logic [STEP_W-1:0] S_PUT_ADV   = 5'd13;
	localparam logic [STEP_W-1:0] S_BACK      = 5'd14;
	localparam logic [STEP_W-1:0] S_BACK_MOVE = 5'd15;
	localparam logic [STEP_W-1:0] S_BACK_WR   = 5'd16;
	localparam logic [STEP_W-1:0] S_NEWL      = 5'd17;
	localparam logic [STEP_W-1:0] S_NEWL_MOVE = 5'd18;
	localparam logic [STEP_W-1:0] S_SCROLL    = 5'd19;
	localparam logic [STEP_W-1:0] S_COPY_RD   = 5'd20;
	localparam logic [STEP_W-1:0] S_COPY_WR   = 5'd21;
	localparam logic [STEP_W-1:0] S_BLANK     = 5'd22;
	localparam logic [STEP_W-1:0] S_BLANK_END = 5'd23;
	localparam logic [STEP_W-1:0] S_DONE      = 5'd24;
	localparam logic [STEP_W-1:0] S_DONE_END  = 5'd25;

	// Control word that does nothing and falls through.
	localparam ctrl_t CTRL_NOP = '{
		cond:     C_NEXT,
		target:   S_IDLE,
		addr_op:  A_HOLD,
		rd:       R_NONE,
		wr:       W_NONE,
		cur:      K_HOLD,
		ld_color: 1'b0,
		ld_value: 1'b0,
		emit:     1'b0,
		wait_in:  1'b0
	};

	// The microprogram. A taken condition jumps to the target, else the next step runs.
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = CTRL_NOP;
		case (step)
			S_IDLE: begin
				c.wait_in = 1'b1;
				c.cond    = C_NO_IN;
				c.target  = S_IDLE;
			end
			S_DISP: begin
				c.cond   = C_OP_PUT;
				c.target = S_PUT;
			end
			S_DISP_RD: begin
				c.cond   = C_OP_READ;
				c.target = S_READ;
			end
			S_COLOR: begin
				c.ld_color = 1'b1;
				c.cond     = C_OP_SET;
				c.target   = S_DONE;
			end
			S_CLEAR: begin
				c.addr_op = A_ZERO;
				c.cond    = C_JUMP;
				c.target  = S_FILL;
			end
			S_FILL: begin
				c.wr      = W_BLANK_ADDR;
				c.addr_op = A_INC;
				c.cond    = C_FILL_MORE;
				c.target  = S_FILL;
			end
			S_HOME: begin
				c.cur    = K_HOME;
				c.cond   = C_ITEM;
				c.target = S_DONE;
			end
			S_TO_IDLE: begin
				c.cond   = C_JUMP;
				c.target = S_IDLE;
			end
			S_READ: begin
				c.rd     = R_CELL;
				c.cond   = C_CELL_OOR;
				c.target = S_DONE;
			end
			S_READ_DATA: begin
				c.ld_value = 1'b1;
				c.cond     = C_JUMP;
				c.target   = S_DONE;
			end
			S_PUT: begin
				c.cond   = C_NL;
				c.target = S_NEWL;
			end
			S_PUT_BS: begin
				c.cond   = C_BS;
				c.target = S_BACK;
			end
			S_PUT_CHAR: begin
				c.wr     = W_CHAR_POS;
				c.cond   = C_COL_LAST;
				c.target = S_NEWL;
			end
			S_PUT_ADV: begin
				c.cur    = K_ADV;
				c.cond   = C_JUMP;
				c.target = S_DONE;
			end
			S_BACK: begin
				c.cond   = C_COL0;
				c.target = S_DONE;
			end
			S_BACK_MOVE: begin
				c.cur = K_BACK;
			end
			S_BACK_WR: begin
				c.wr     = W_BLANK_POS;
				c.cond   = C_JUMP;
				c.target = S_DONE;
			end
			S_NEWL: begin
				c.cond   = C_ROW_LAST;
				c.target = S_SCROLL;
			end
			S_NEWL_MOVE: begin
				c.cur    = K_NEWL;
				c.cond   = C_JUMP;
				c.target = S_DONE;
			end
			S_SCROLL: begin
				c.addr_op = A_ZERO;
				c.cur     = K_BOTTOM;
			end
			S_COPY_RD: begin
				c.rd = R_AHEAD;
			end
			S_COPY_WR: begin
				c.wr      = W_COPY_ADDR;
				c.addr_op = A_INC;
				c.cond    = C_COPY_MORE;
				c.target  = S_COPY_RD;
			end
			S_BLANK: begin
				c.wr      = W_BLANK_ADDR;
				c.addr_op = A_INC;
				c.cond    = C_FILL_MORE;
				c.target  = S_BLANK;
			end
			S_BLANK_END: begin
				c.cond   = C_JUMP;
				c.target = S_DONE;
			end
			S_DONE: begin
				c.emit   = 1'b1;
				c.cond   = C_OUT_BUSY;
				c.target = S_DONE;
			end
			S_DONE_END: begin
				c.cond   = C_JUMP;
				c.target = S_IDLE;
			end
			default: begin
				c.cond   = C_JUMP;
				c.target = S_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

/* sv/tmtw_seq.sv */
module tmtw_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  tmtw_pkg::flags_t  flags,
	output tmtw_pkg::ctrl_t   ctrl
);

	logic [tmtw_pkg::STEP_W-1:0] step_q;
	logic [tmtw_pkg::STEP_W-1:0] step_d;
	logic                        take;

	// Control word of the current step.
	assign ctrl = tmtw_pkg::ucode(step_q);

	// Branch condition select.
	always_comb begin
		case (ctrl.cond)
			tmtw_pkg::C_NEXT:      take = 1'b0;
			tmtw_pkg::C_JUMP:      take = 1'b1;
			tmtw_pkg::C_NO_IN:     take = !flags.in_take;
			tmtw_pkg::C_OP_PUT:    take = flags.op_put;
			tmtw_pkg::C_OP_READ:   take = flags.op_read;
			tmtw_pkg::C_OP_SET:    take = flags.op_set;
			tmtw_pkg::C_NL:        take = flags.is_nl;
			tmtw_pkg::C_BS:        take = flags.is_bs;
			tmtw_pkg::C_COL0:      take = flags.col0;
			tmtw_pkg::C_COL_LAST:  take = flags.col_last;
			tmtw_pkg::C_ROW_LAST:  take = flags.row_last;
			tmtw_pkg::C_FILL_MORE: take = flags.fill_more;
			tmtw_pkg::C_COPY_MORE: take = flags.copy_more;
			tmtw_pkg::C_ITEM:      take = flags.item;
			tmtw_pkg::C_OUT_BUSY:  take = flags.out_busy;
			tmtw_pkg::C_CELL_OOR:  take = flags.cell_oor;
			default:               take = 1'b0;
		endcase
	end

	assign step_d = take ? ctrl.target : step_q + 1'b1;

	// Step counter. Reset starts the blanking sweep of the screen store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= tmtw_pkg::S_FILL;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

/* sv/text_mode_terminal_writer_top.sv */
// Character-cell text terminal with an 80 by 25 screen store of 16-bit cells
// (character in the low byte, color in the high byte), a cursor and a current
// color, run by a small microprogram over one screen memory with one write
// port and one registered read port. Every accepted word returns exactly one
// result word carrying the cursor position and, for a cell read, the cell
// contents. A clear walks all 2000 cells at one a cycle. A newline past the
// last row copies 1920 cells through the memory's registered read port and
// blanks the bottom row. After reset the block first blanks the whole store
// and holds in_stall high until that is done. The result sits in an output
// register, so the next word is taken while a result still waits.
module text_mode_terminal_writer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [7:0]                    char_code,
	input  logic [7:0]                    color_value,
	input  logic [tmtw_pkg::POS_W-1:0]    cell_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tmtw_pkg::POS_W-1:0]    cursor_position,
	output logic [tmtw_pkg::CELL_W-1:0]   cell_value
);

	localparam int POS_W  = tmtw_pkg::POS_W;
	localparam int ROW_W  = tmtw_pkg::ROW_W;
	localparam int COL_W  = tmtw_pkg::COL_W;
	localparam int CELL_W = tmtw_pkg::CELL_W;

	localparam logic [POS_W-1:0] COLS_P      = POS_W'(tmtw_pkg::COLUMNS);
	localparam logic [POS_W-1:0] CELLS_P     = POS_W'(tmtw_pkg::CELL_COUNT);
	localparam logic [POS_W-1:0] LAST_CELL   = POS_W'(tmtw_pkg::CELL_COUNT - 1);
	localparam logic [POS_W-1:0] LAST_COPY   =
		POS_W'(tmtw_pkg::CELL_COUNT - tmtw_pkg::COLUMNS - 1);
	localparam logic [POS_W-1:0] BOTTOM_POS  =
		POS_W'((tmtw_pkg::ROWS - 1) * tmtw_pkg::COLUMNS);
	localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(tmtw_pkg::ROWS - 1);
	localparam logic [COL_W-1:0] LAST_COL    = COL_W'(tmtw_pkg::COLUMNS - 1);

	tmtw_pkg::ctrl_t  ctrl;
	tmtw_pkg::flags_t flags;

	// Latched input word.
	tmtw_pkg::op_t    op_q;
	logic [7:0]       ch_q;
	logic [7:0]       color_in_q;
	logic [POS_W-1:0] cell_q;

	// Terminal state and sweep address.
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [POS_W-1:0]  pos_q;
	logic [7:0]        color_q;
	logic [POS_W-1:0]  addr_q;
	logic              item_q;
	logic [CELL_W-1:0] val_q;

	// Output register.
	logic              out_valid_q;
	logic [POS_W-1:0]  cursor_q;
	logic [CELL_W-1:0] cell_out_q;

	// Screen memory port signals.
	logic [CELL_W-1:0] mem [tmtw_pkg::CELL_COUNT];
	logic [CELL_W-1:0] rdata_q;
	logic              we;
	logic [POS_W-1:0]  waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [POS_W-1:0]  raddr;

	logic in_take;
	logic out_busy;
	logic emit;

	tmtw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// Handshake.
	assign in_stall = !ctrl.wait_in;
	assign in_take  = in_valid && ctrl.wait_in;
	assign out_busy = out_valid_q && out_stall;
	assign emit     = ctrl.emit && !out_busy;

	// Status for the sequencer.
	always_comb begin
		flags.in_take   = in_take;
		flags.op_put    = (op_q == tmtw_pkg::OP_PUT);
		flags.op_read   = (op_q == tmtw_pkg::OP_READ);
		flags.op_set    = (op_q == tmtw_pkg::OP_SET);
		flags.is_nl     = (ch_q == tmtw_pkg::CH_NEWLINE);
		flags.is_bs     = (ch_q == tmtw_pkg::CH_BACKSPACE);
		flags.col0      = (col_q == '0);
		flags.col_last  = (col_q == LAST_COL);
		flags.row_last  = (row_q == LAST_ROW);
		flags.fill_more = (addr_q != LAST_CELL);
		flags.copy_more = (addr_q != LAST_COPY);
		flags.item      = item_q;
		flags.out_busy  = out_busy;
		flags.cell_oor  = (cell_q >= CELLS_P);
	end

	// Input word capture.
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q       <= tmtw_pkg::op_t'(opcode);
			ch_q       <= char_code;
			color_in_q <= color_value;
			cell_q     <= cell_index;
		end
	end

	// Read value of the current word: zero unless a cell read loads it.
	always_ff @(posedge clk) begin
		if (in_take) begin
			val_q <= '0;
		end else if (ctrl.ld_value) begin
			val_q <= rdata_q;
		end
	end

	// Pending word flag, set on accept and cleared when its result is issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= 1'b0;
		end else if (in_take) begin
			item_q <= 1'b1;
		end else if (emit) begin
			item_q <= 1'b0;
		end
	end

	// Sweep address counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else begin
			case (ctrl.addr_op)
				tmtw_pkg::A_ZERO: addr_q <= '0;
				tmtw_pkg::A_INC:  addr_q <= addr_q + 1'b1;
				default:          addr_q <= addr_q;
			endcase
		end
	end

	// Current color.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= tmtw_pkg::RESET_COLOR;
		end else if (ctrl.ld_color) begin
			color_q <= color_in_q;
		end
	end

	// Cursor row, column and linear position, kept in step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			pos_q <= '0;
		end else begin
			case (ctrl.cur)
				tmtw_pkg::K_HOME: begin
					row_q <= '0;
					col_q <= '0;
					pos_q <= '0;
				end
				tmtw_pkg::K_ADV: begin
					col_q <= col_q + 1'b1;
					pos_q <= pos_q + 1'b1;
				end
				tmtw_pkg::K_BACK: begin
					col_q <= col_q - 1'b1;
					pos_q <= pos_q - 1'b1;
				end
				tmtw_pkg::K_NEWL: begin
					row_q <= row_q + 1'b1;
					col_q <= '0;
					pos_q <= pos_q - POS_W'(col_q) + COLS_P;
				end
				tmtw_pkg::K_BOTTOM: begin
					row_q <= LAST_ROW;
					col_q <= '0;
					pos_q <= BOTTOM_POS;
				end
				default: begin
					row_q <= row_q;
				end
			endcase
		end
	end

	// Screen memory write port selection.
	always_comb begin
		we    = 1'b1;
		waddr = addr_q;
		wdata = {color_q, tmtw_pkg::CH_SPACE};
		case (ctrl.wr)
			tmtw_pkg::W_BLANK_ADDR: begin
				waddr = addr_q;
			end
			tmtw_pkg::W_BLANK_POS: begin
				waddr = pos_q;
			end
			tmtw_pkg::W_CHAR_POS: begin
				waddr = pos_q;
				wdata = {color_q, ch_q};
			end
			tmtw_pkg::W_COPY_ADDR: begin
				wdata = rdata_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Screen memory read port selection. Out-of-range reads are not issued.
	always_comb begin
		case (ctrl.rd)
			tmtw_pkg::R_CELL: begin
				re    = !flags.cell_oor;
				raddr = cell_q;
			end
			tmtw_pkg::R_AHEAD: begin
				re    = 1'b1;
				raddr = addr_q + COLS_P;
			end
			default: begin
				re    = 1'b0;
				raddr = addr_q;
			end
		endcase
	end

	// Screen memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cursor_q   <= pos_q;
			cell_out_q <= val_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor_position = cursor_q;
	assign cell_value      = cell_out_q;

`ifndef NO_ASSERTIONS
	// A new word is only taken once the previous one has issued its result.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |-> !item_q)
		else $error("word accepted while another is still in work");

	// Every memory write stays inside the screen.
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (waddr < CELLS_P))
		else $error("screen write out of range");

	// A result word only appears for a word that was accepted.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(item_q))
		else $error("result word without an accepted word");

	// The linear cursor position tracks row and column.
	a_pos_track: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == POS_W'(row_q * tmtw_pkg::COLUMNS + col_q))
		else $error("cursor position out of step with row and column");

	// The cursor never leaves the screen.
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= LAST_COL) && (row_q <= LAST_ROW))
		else $error("cursor outside the screen");
`endif

endmodule
